FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, ignored while reset is high.
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds through reset.
`define CHK_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/intrd_pkg.sv
`timescale 1ns / 1ps

package intrd_pkg;

  localparam int DEF_MAX_RADIX = 16;
  localparam int MAX_DIGITS    = 32;
  localparam int RADIX_W       = 5;
  localparam int DIGIT_W       = 4;
  localparam int COUNT_W       = 6;
  localparam int VALUE_W       = 32;
  localparam int SYM_W         = 8;
  localparam int SYMTAB_W      = 128;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;

  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_HI  = 2'd2;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic sign;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_done;
    logic count_one;
    logic neg;
  } dp_sts_t;

  // floor(2^32 / r), the reciprocal used to estimate a quotient
  function automatic logic [VALUE_W-1:0] recip(input logic [RADIX_W-1:0] r);
    logic [VALUE_W-1:0] m;
    case (r)
      5'd2:    m = 32'h8000_0000;
      5'd3:    m = 32'h5555_5555;
      5'd4:    m = 32'h4000_0000;
      5'd5:    m = 32'h3333_3333;
      5'd6:    m = 32'h2AAA_AAAA;
      5'd7:    m = 32'h2492_4924;
      5'd8:    m = 32'h2000_0000;
      5'd9:    m = 32'h1C71_C71C;
      5'd10:   m = 32'h1999_9999;
      5'd11:   m = 32'h1745_D174;
      5'd12:   m = 32'h1555_5555;
      5'd13:   m = 32'h13B1_3B13;
      5'd14:   m = 32'h1249_2492;
      5'd15:   m = 32'h1111_1111;
      5'd16:   m = 32'h1000_0000;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

FILE: sv/intrd_cfg.sv
`timescale 1ns / 1ps

module intrd_cfg
  import intrd_pkg::*;
#(
  parameter int MAX_RADIX = DEF_MAX_RADIX
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [RADIX_W-1:0]    act_radix,
  output logic [SYMTAB_W-1:0]   symbols,
  output logic                  cfg_ok
);

  localparam logic [RADIX_W-1:0] MAX_R = RADIX_W'(MAX_RADIX);

  logic [RADIX_W-1:0]    radix;
  logic [CFG_DATA_W-1:0] sym_low;
  logic [CFG_DATA_W-1:0] sym_high;
  logic [SYM_W-1:0]      sym [MAX_RADIX];
  logic                  bad;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix    <= '0;
      sym_low  <= '0;
      sym_high <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RADIX:   radix    <= cfg_data[RADIX_W-1:0];
        REG_SYM_LOW: sym_low  <= cfg_data;
        REG_SYM_HI:  sym_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign symbols   = {sym_high, sym_low};
  assign act_radix = (radix > MAX_R) ? MAX_R : radix;

  always_comb begin
    for (int i = 0; i < MAX_RADIX; i++) begin
      sym[i] = symbols[i*SYM_W +: SYM_W];
    end
  end

  // every pair of symbols in use is compared
  always_comb begin
    bad = (act_radix < RADIX_W'(2));
    for (int i = 0; i < MAX_RADIX; i++) begin
      if (RADIX_W'(i) < act_radix) begin
        if (sym[i] == SYM_PLUS || sym[i] == SYM_MINUS) bad = 1'b1;
        for (int j = 0; j < i; j++) begin
          if (sym[i] == sym[j]) bad = 1'b1;
        end
      end
    end
  end

  assign cfg_ok = !bad;

endmodule

FILE: sv/intrd_dp.sv
`timescale 1ns / 1ps

module intrd_dp
  import intrd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  output dp_sts_t             sts,
  input  logic [VALUE_W-1:0]  value,
  input  logic [RADIX_W-1:0]  act_radix,
  input  logic [SYMTAB_W-1:0] symbols,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SYM_W-1:0]    out_sym,
  output logic                out_last
);

  logic [VALUE_W-1:0]   quotient;
  logic [VALUE_W-1:0]   prod_hi;
  logic                 neg;
  logic [COUNT_W-1:0]   count;
  logic [DIGIT_W-1:0]   stack [MAX_DIGITS];

  logic [2*VALUE_W-1:0] prod_full;
  logic [5:0]           r6;
  logic [5:0]           qr_low;
  logic [5:0]           rem6;
  logic                 ge;
  logic [DIGIT_W-1:0]   digit;
  logic [VALUE_W-1:0]   q_fix;
  logic [DIGIT_W-1:0]   top_digit;
  logic [COUNT_W-1:0]   count_dec;

  assign prod_full = (2*VALUE_W)'(quotient) * (2*VALUE_W)'(recip(act_radix));

  // estimate is low by at most one, so the remainder stays below 2r
  assign r6     = 6'(act_radix);
  assign qr_low = prod_hi[5:0] * r6;
  assign rem6   = quotient[5:0] - qr_low;
  assign ge     = (rem6 >= r6);
  assign digit  = ge ? DIGIT_W'(rem6 - r6) : DIGIT_W'(rem6);
  assign q_fix  = ge ? (prod_hi + VALUE_W'(1)) : prod_hi;

  assign count_dec = count - COUNT_W'(1);
  assign top_digit = stack[count_dec[4:0]];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quotient <= value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
      neg      <= value[VALUE_W-1];
    end else if (cmd.div) begin
      quotient <= q_fix;
    end
    if (cmd.mul) prod_hi <= prod_full[2*VALUE_W-1:VALUE_W];
    if (cmd.div) stack[count[4:0]] <= digit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= '0;
    end else if (cmd.div) begin
      count <= count + COUNT_W'(1);
    end else if (cmd.emit) begin
      count <= count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.sign || cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sign) begin
      out_sym  <= SYM_MINUS;
      out_last <= 1'b0;
    end else if (cmd.emit) begin
      out_sym  <= symbols[{top_digit, 3'b000} +: SYM_W];
      out_last <= (count == COUNT_W'(1));
    end
  end

  assign sts.out_free  = !out_valid || out_ready;
  assign sts.div_done  = (q_fix == '0) || (count == COUNT_W'(MAX_DIGITS - 1));
  assign sts.count_one = (count == COUNT_W'(1));
  assign sts.neg       = neg;

endmodule

FILE: sv/intrd_ctrl.sv
`timescale 1ns / 1ps

module intrd_ctrl
  import intrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      cfg_ok,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && cfg_ok) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_done) begin
          state_next = sts.neg ? S_SIGN : S_EMIT;
        end else begin
          state_next = S_MUL;
        end
      end
      S_SIGN: begin
        if (sts.out_free) begin
          cmd.sign   = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.count_one) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/integer_to_radix_digits_top.sv
`timescale 1ns / 1ps

// Channel | Dir | Beat content
// s_*     | in  | s_tdata[31:0] = value (signed)
// m_*     | out | m_tdata[7:0] = symbol, m_tlast = last
// cfg_*   | in  | cfg_index = register (0 radix, 1 symbols_low, 2 symbols_high),
//         |     | cfg_data = value
//
// One number first goes through digit extraction (D digits, each through the
// reciprocal multiplier and its correction), then gives one output beat per
// digit, plus one for a minus sign.
// Reset is synchronous and clears control state; digits are not cleared.
// A stalled sink holds the output register and the symbol sequencer.
// A number seen under an invalid configuration is taken and yields no beats.

module integer_to_radix_digits_top
  import intrd_pkg::*;
#(
  parameter int MAX_RADIX = DEF_MAX_RADIX
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [VALUE_W-1:0]    s_tdata,    // [31:0] value
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [SYM_W-1:0]      m_tdata,    // [7:0] symbol
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [RADIX_W-1:0]  act_radix;
  logic [SYMTAB_W-1:0] symbols;
  logic                cfg_ok;
  ctrl_cmd_t           cmd;
  dp_sts_t             sts;

  // configuration registers and the symbol table check
  intrd_cfg #(
    .MAX_RADIX (MAX_RADIX)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .act_radix (act_radix),
    .symbols   (symbols),
    .cfg_ok    (cfg_ok)
  );

  // sequencer: accept, divide loop, sign, emit
  intrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cfg_ok   (cfg_ok),
    .sts      (sts),
    .cmd      (cmd)
  );

  // magnitude, divider, digit stack and output register
  intrd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .value     (s_tdata),
    .act_radix (act_radix),
    .symbols   (symbols),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_sym   (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

FILE: sv/intrd_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module intrd_checker
  import intrd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [SYM_W-1:0]      m_tdata,
  input logic                  m_tlast
);

  `CHK_ASSERT(a_out_hold,
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast),
    "output beat changed while stalled")
  `CHK_ASSERT_RST(a_rst_quiet, rst |=> !m_tvalid, "output valid right after reset")
  `CHK_ASSERT(a_minus_not_last, m_tvalid && m_tdata == SYM_MINUS |-> !m_tlast,
    "minus sign marked last")
  `CHK_ASSERT(a_accept_between, s_tvalid && s_tready |-> !m_tvalid || m_tlast,
    "number taken in the middle of a previous one")

endmodule

bind integer_to_radix_digits_top intrd_checker u_chk (.*);
